@@ hw/rtl/cac_pkg.sv @@
// shared types, codes and constants for the coloured arc closure insert core
package cac_pkg;

  // sizes
  localparam int MAX_VERTICES = 12;
  localparam int NUM_COLOURS  = 4;
  localparam int VERT_W       = 4;
  localparam int COLOUR_W     = 2;
  localparam int ENTRY_W      = 3;
  localparam int COUNT_W      = 8;
  localparam int HIGH_W       = 3;
  localparam int CIDX_W       = (NUM_COLOURS > 1) ? $clog2(NUM_COLOURS) : 1;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [COUNT_W-1:0]  ARC_LIMIT    = COUNT_W'(132);
  localparam logic [VERT_W-1:0]   MIN_VERTICES = VERT_W'(3);
  localparam logic [VERT_W-1:0]   MAX_VERT_CNT = VERT_W'(MAX_VERTICES);
  localparam logic [COLOUR_W:0]   COLOUR_LIMIT = (COLOUR_W + 1)'(NUM_COLOURS);

  // request actions
  localparam logic [1:0] ACT_PROBE  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // reject reasons
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_RAINBOW = 2'd1;
  localparam logic [1:0] REASON_REACH   = 2'd2;
  localparam logic [1:0] REASON_BAD     = 2'd3;

  // register indexes
  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_RAINBOW_GUARD = 1'b1;

  // colour matrix entry: colour plus one, zero for no arc
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef entry_t [MAX_VERTICES-1:0] entry_row_t;

  // reachability rows for one colour
  typedef logic [MAX_VERTICES-1:0] reach_row_t;
  typedef reach_row_t [MAX_VERTICES-1:0] reach_set_t;

  // identity closure: row x holds only bit x
  function automatic reach_set_t identity_set();
    reach_set_t s;
    s = '0;
    for (int x = 0; x < MAX_VERTICES; x++) begin
      s[x][x] = 1'b1;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/coloured_arc_closure_insert_core.sv @@
// coloured arc insert with incremental per-colour reachability closure
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   in       | in_valid, in_ready, action, tail_vertex, ...   | request in
//   out      | out_valid, out_ready, accepted, reject_reason  | result out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata   | APB slave
//
// one request per cycle sustained while the result side is not stalled; the
// input register loads at the edge that takes the request and the result
// register loads from it when the result side has room
// the whole check and closure update is one pass of bit-parallel logic
// over the twelve rows of the request's colour, so state written by one
// request is seen by the very next one
// rst is synchronous: the store returns to the identity closure, counts to
// zero, vertex_count to 12 and rainbow_guard to 0 in the same edge
// a stalled result holds the input register, which then stalls the input
module coloured_arc_closure_insert_core (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [cac_pkg::VERT_W-1:0]    tail_vertex,
  input  logic [cac_pkg::VERT_W-1:0]    head_vertex,
  input  logic [cac_pkg::COLOUR_W-1:0]  colour,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [1:0]                    reject_reason,
  output logic [cac_pkg::HIGH_W-1:0]    colours_in_use,
  output logic [cac_pkg::COUNT_W-1:0]   arcs_placed,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cac_pkg::ADDR_W-1:0]    paddr,
  input  logic [cac_pkg::DATA_W-1:0]    pwdata,
  output logic [cac_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // configuration registers
  logic [cac_pkg::VERT_W-1:0]   vertex_count;
  logic                         rainbow_guard;

  // store: out_rows[t][h] and in_cols[h][t] both hold the colour of t->h
  cac_pkg::entry_row_t          out_rows [cac_pkg::MAX_VERTICES];
  cac_pkg::entry_row_t          in_cols  [cac_pkg::MAX_VERTICES];
  cac_pkg::reach_set_t          reach    [cac_pkg::NUM_COLOURS];
  logic [cac_pkg::HIGH_W-1:0]   colour_high;
  logic [cac_pkg::COUNT_W-1:0]  arc_counter;

  // input register
  logic                         s1_valid;
  logic [1:0]                   s1_action;
  logic [cac_pkg::VERT_W-1:0]   s1_tail;
  logic [cac_pkg::VERT_W-1:0]   s1_head;
  logic [cac_pkg::COLOUR_W-1:0] s1_colour;

  // check and update logic
  logic                         advance;
  logic [cac_pkg::VERT_W-1:0]   n_act;
  logic [cac_pkg::CIDX_W-1:0]   cidx;
  cac_pkg::entry_t              c_code;
  logic                         bad;
  logic                         rainbow;
  logic                         reach_hit;
  cac_pkg::reach_set_t          cur;
  cac_pkg::reach_row_t          succ;
  cac_pkg::reach_set_t          nxt;
  logic [cac_pkg::VERT_W-1:0]   pred_idx;
  logic [1:0]                   reason;
  logic                         commit;
  logic [cac_pkg::HIGH_W-1:0]   colour_high_next;
  logic [cac_pkg::COUNT_W-1:0]  arc_counter_next;
  cac_pkg::entry_t              p;
  cac_pkg::entry_t              q;

  // handshake
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign pready   = 1'b1;

  // register read
  always_comb begin
    case (paddr[2])
      cac_pkg::REG_VERTEX_COUNT:  prdata = cac_pkg::DATA_W'(vertex_count);
      cac_pkg::REG_RAINBOW_GUARD: prdata = cac_pkg::DATA_W'(rainbow_guard);
      default:                    prdata = '0;
    endcase
  end

  // vertex count clamped to the supported range
  always_comb begin
    if (vertex_count < cac_pkg::MIN_VERTICES) begin
      n_act = cac_pkg::MIN_VERTICES;
    end else if (vertex_count > cac_pkg::MAX_VERT_CNT) begin
      n_act = cac_pkg::MAX_VERT_CNT;
    end else begin
      n_act = vertex_count;
    end
  end

  assign cidx   = cac_pkg::CIDX_W'(s1_colour);
  assign c_code = cac_pkg::ENTRY_W'(s1_colour) + cac_pkg::ENTRY_W'(1);

  // bad vertex, tail equal to head, or colour outside the palette
  assign bad = (s1_tail >= n_act) || (s1_head >= n_act) || (s1_tail == s1_head) ||
               ({1'b0, s1_colour} >= cac_pkg::COLOUR_LIMIT);

  // rainbow triangle through any third vertex w: head->w, w->tail
  always_comb begin
    rainbow = 1'b0;
    p = '0;
    q = '0;
    for (int w = 0; w < cac_pkg::MAX_VERTICES; w++) begin
      p = out_rows[s1_head][w];
      q = in_cols[s1_tail][w];
      if ((cac_pkg::VERT_W'(w) < n_act) && (p != '0) && (q != '0) &&
          (p != c_code) && (q != c_code) && (p != q)) begin
        rainbow = 1'b1;
      end
    end
  end

  // close the new arc into the colour's rows and look for a cycle predecessor
  always_comb begin
    cur       = reach[cidx];
    succ      = cur[s1_head];
    nxt       = cur;
    reach_hit = 1'b0;
    pred_idx  = '0;
    for (int x = 0; x < cac_pkg::MAX_VERTICES; x++) begin
      if ((cac_pkg::VERT_W'(x) < n_act) && cur[x][s1_tail]) begin
        nxt[x] = cur[x] | succ;
      end
    end
    for (int x = 0; x < cac_pkg::MAX_VERTICES; x++) begin
      pred_idx = (x == 0) ? (n_act - cac_pkg::VERT_W'(1)) : cac_pkg::VERT_W'(x - 1);
      if ((cac_pkg::VERT_W'(x) < n_act) && nxt[x][pred_idx]) begin
        reach_hit = 1'b1;
      end
    end
  end

  // reason in priority order
  always_comb begin
    if (s1_action == cac_pkg::ACT_CLEAR) begin
      reason = cac_pkg::REASON_NONE;
    end else if (bad) begin
      reason = cac_pkg::REASON_BAD;
    end else if (rainbow_guard && rainbow) begin
      reason = cac_pkg::REASON_RAINBOW;
    end else if (reach_hit) begin
      reason = cac_pkg::REASON_REACH;
    end else begin
      reason = cac_pkg::REASON_NONE;
    end
  end

  assign commit = (s1_action == cac_pkg::ACT_INSERT) && (reason == cac_pkg::REASON_NONE);

  // counts after this request
  always_comb begin
    colour_high_next = colour_high;
    arc_counter_next = arc_counter;
    if (s1_action == cac_pkg::ACT_CLEAR) begin
      colour_high_next = '0;
      arc_counter_next = '0;
    end else if (commit) begin
      if (c_code > colour_high) begin
        colour_high_next = c_code;
      end
      if (arc_counter < cac_pkg::ARC_LIMIT) begin
        arc_counter_next = arc_counter + cac_pkg::COUNT_W'(1);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= cac_pkg::MAX_VERT_CNT;
      rainbow_guard <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        cac_pkg::REG_VERTEX_COUNT:  vertex_count  <= pwdata[cac_pkg::VERT_W-1:0];
        cac_pkg::REG_RAINBOW_GUARD: rainbow_guard <= pwdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_tail   <= tail_vertex;
      s1_head   <= head_vertex;
      s1_colour <= colour;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      accepted       <= (reason == cac_pkg::REASON_NONE);
      reject_reason  <= reason;
      colours_in_use <= colour_high_next;
      arcs_placed    <= arc_counter_next;
    end
  end

  // store update: reset or clear, or commit of an accepted insert
  always_ff @(posedge clk) begin
    if (rst || (advance && s1_action == cac_pkg::ACT_CLEAR)) begin
      for (int i = 0; i < cac_pkg::MAX_VERTICES; i++) begin
        out_rows[i] <= '0;
        in_cols[i]  <= '0;
      end
      for (int k = 0; k < cac_pkg::NUM_COLOURS; k++) begin
        reach[k] <= cac_pkg::identity_set();
      end
      colour_high <= '0;
      arc_counter <= '0;
    end else if (advance && commit) begin
      out_rows[s1_tail][s1_head] <= c_code;
      in_cols[s1_head][s1_tail]  <= c_code;
      reach[cidx]                <= nxt;
      colour_high                <= colour_high_next;
      arc_counter                <= arc_counter_next;
    end
  end

  // a result flag agrees with its reason
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accepted == (reject_reason == cac_pkg::REASON_NONE)))
    else $error("accepted flag disagrees with reject reason");

  // the arc counter saturates
  assert property (@(posedge clk) disable iff (rst)
    arc_counter <= cac_pkg::ARC_LIMIT)
    else $error("arc counter beyond its limit");

  // a clear leaves zero counts
  assert property (@(posedge clk) disable iff (rst)
    (advance && s1_action == cac_pkg::ACT_CLEAR) |=> (arc_counter == '0 && colour_high == '0))
    else $error("clear did not reset the counts");

  // a rejected request leaves the counts alone
  assert property (@(posedge clk) disable iff (rst)
    (advance && reason != cac_pkg::REASON_NONE) |=> ($stable(arc_counter) && $stable(colour_high)))
    else $error("rejected request changed the store");

  // the result shows the committed counts
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (arcs_placed == arc_counter && colours_in_use == colour_high))
    else $error("result counts differ from the store");

endmodule

@@ sim/coloured_arc_closure_insert_checker.sv @@
// request/result monitor with arc closure prediction and result comparison
module coloured_arc_closure_insert_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [cac_pkg::VERT_W-1:0]    tail_vertex,
  input  logic [cac_pkg::VERT_W-1:0]    head_vertex,
  input  logic [cac_pkg::COLOUR_W-1:0]  colour,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          accepted,
  input  logic [1:0]                    reject_reason,
  input  logic [cac_pkg::HIGH_W-1:0]    colours_in_use,
  input  logic [cac_pkg::COUNT_W-1:0]   arcs_placed,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [cac_pkg::ADDR_W-1:0]    paddr,
  input  logic [cac_pkg::DATA_W-1:0]    pwdata,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                         acc;
    logic [1:0]                   why;
    logic [cac_pkg::HIGH_W-1:0]   high;
    logic [cac_pkg::COUNT_W-1:0]  placed;
  } arc_result_t;

  // predicted store and register copies
  cac_pkg::entry_t              arc_colour [cac_pkg::MAX_VERTICES][cac_pkg::MAX_VERTICES];
  cac_pkg::reach_set_t          reach_by_colour [cac_pkg::NUM_COLOURS];
  logic [cac_pkg::HIGH_W-1:0]   top_colour;
  logic [cac_pkg::COUNT_W-1:0]  placed_count;
  logic [cac_pkg::VERT_W-1:0]   cfg_vertices;
  logic                         cfg_rainbow_guard;

  arc_result_t expected_results [$];

  // back to empty store with identity closure
  task automatic wipe_store();
    for (int a = 0; a < cac_pkg::MAX_VERTICES; a++) begin
      for (int b = 0; b < cac_pkg::MAX_VERTICES; b++) begin
        arc_colour[a][b] = '0;
      end
    end
    for (int k = 0; k < cac_pkg::NUM_COLOURS; k++) begin
      reach_by_colour[k] = '0;
      for (int x = 0; x < cac_pkg::MAX_VERTICES; x++) begin
        reach_by_colour[k][x][x] = 1'b1;
      end
    end
    top_colour   = '0;
    placed_count = '0;
  endtask

  // wipe the store on a clear, else check one arc request against the store, commit if it is an accepted insert
  task automatic predict_arc_request(input logic [1:0] act,
                                     input logic [cac_pkg::VERT_W-1:0] u,
                                     input logic [cac_pkg::VERT_W-1:0] v,
                                     input logic [cac_pkg::COLOUR_W-1:0] c,
                                     output arc_result_t res);
    int                  n;
    int                  cx;
    int                  cy;
    logic [1:0]          why;
    cac_pkg::reach_set_t grown;
    cac_pkg::reach_row_t succ;
    cac_pkg::entry_t     p;
    cac_pkg::entry_t     q;
    n = int'(cfg_vertices);
    if (n < int'(cac_pkg::MIN_VERTICES)) n = int'(cac_pkg::MIN_VERTICES);
    if (n > cac_pkg::MAX_VERTICES) n = cac_pkg::MAX_VERTICES;
    why = cac_pkg::REASON_NONE;
    if (act == cac_pkg::ACT_CLEAR) begin
      wipe_store();
    end else if (int'(u) >= n || int'(v) >= n || u == v ||
                 int'(c) >= cac_pkg::NUM_COLOURS) begin
      why = cac_pkg::REASON_BAD;
    end else begin
      // three distinct colours around head -> w -> tail plus the new arc
      if (cfg_rainbow_guard) begin
        for (int w = 0; w < n; w++) begin
          p = arc_colour[v][w];
          q = arc_colour[w][u];
          if (why == cac_pkg::REASON_NONE && p != '0 && q != '0) begin
            cx = int'(p) - 1;
            cy = int'(q) - 1;
            if (int'(c) != cx && int'(c) != cy && cx != cy) why = cac_pkg::REASON_RAINBOW;
          end
        end
      end
      // close the arc into its colour and look for a reach to the cycle predecessor
      if (why == cac_pkg::REASON_NONE) begin
        grown = reach_by_colour[c];
        succ  = reach_by_colour[c][v];
        for (int x = 0; x < n; x++) begin
          if (reach_by_colour[c][x][u]) grown[x] = grown[x] | succ;
        end
        for (int x = 0; x < n; x++) begin
          if (grown[x][(x + n - 1) % n]) why = cac_pkg::REASON_REACH;
        end
      end
      if (why == cac_pkg::REASON_NONE && act == cac_pkg::ACT_INSERT) begin
        arc_colour[u][v]   = cac_pkg::entry_t'(int'(c) + 1);
        reach_by_colour[c] = grown;
        if (int'(c) + 1 > int'(top_colour)) top_colour = cac_pkg::HIGH_W'(int'(c) + 1);
        if (placed_count < cac_pkg::ARC_LIMIT) begin
          placed_count = placed_count + cac_pkg::COUNT_W'(1);
        end
      end
    end
    res.acc    = (why == cac_pkg::REASON_NONE);
    res.why    = why;
    res.high   = top_colour;
    res.placed = placed_count;
  endtask

  // watch config writes, results and requests on every edge
  always @(posedge clk) begin : watch
    arc_result_t got;
    arc_result_t want;
    arc_result_t fresh;
    if (rst) begin
      wipe_store();
      cfg_vertices      = cac_pkg::MAX_VERT_CNT;
      cfg_rainbow_guard = 1'b0;
      expected_results.delete();
      fail_count        = 0;
      results_checked   = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[cac_pkg::ADDR_W-1:2] == cac_pkg::REG_VERTEX_COUNT) begin
          cfg_vertices = pwdata[cac_pkg::VERT_W-1:0];
        end else if (paddr[cac_pkg::ADDR_W-1:2] == cac_pkg::REG_RAINBOW_GUARD) begin
          cfg_rainbow_guard = pwdata[0];
        end
      end
      // compare result against the oldest prediction
      if (out_valid && out_ready) begin
        got = {accepted, reject_reason, colours_in_use, arcs_placed};
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: acc=%0d reason=%0d colours=%0d arcs=%0d",
                   $time, got.acc, got.why, got.high, got.placed);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.acc !== want.acc || got.why !== want.why || got.high !== want.high ||
              got.placed !== want.placed) begin
            fail_count++;
            $display("%0t mismatch: expected acc=%0d reason=%0d colours=%0d arcs=%0d",
                     $time, want.acc, want.why, want.high, want.placed);
            $display("%0t           actual   acc=%0d reason=%0d colours=%0d arcs=%0d",
                     $time, got.acc, got.why, got.high, got.placed);
          end
        end
      end
      // accepted request
      if (in_valid && in_ready) begin
        predict_arc_request(action, tail_vertex, head_vertex, colour, fresh);
        expected_results = {expected_results, fresh};
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ sim/coloured_arc_closure_insert_core_tb.sv @@
// top testbench: clock, reset, request stimulus, config writes and verdict
module coloured_arc_closure_insert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    action = cac_pkg::ACT_PROBE;
  logic [cac_pkg::VERT_W-1:0]    tail_vertex = '0;
  logic [cac_pkg::VERT_W-1:0]    head_vertex = '0;
  logic [cac_pkg::COLOUR_W-1:0]  colour = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          accepted;
  logic [1:0]                    reject_reason;
  logic [cac_pkg::HIGH_W-1:0]    colours_in_use;
  logic [cac_pkg::COUNT_W-1:0]   arcs_placed;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cac_pkg::ADDR_W-1:0]    paddr = '0;
  logic [cac_pkg::DATA_W-1:0]    pwdata = '0;
  logic [cac_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  int fail_count;
  int pending;
  int results_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int settings_used = 0;

  coloured_arc_closure_insert_core u_top (.*);

  coloured_arc_closure_insert_checker u_checker (.*);

  always #6 clk = ~clk;

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("coloured_arc_closure_insert_core_tb: done, errors");
    $finish;
  end

  // one request with optional idle cycles ahead of it
  task automatic send_request(input logic [1:0] act, input logic [cac_pkg::VERT_W-1:0] t,
                              input logic [cac_pkg::VERT_W-1:0] h,
                              input logic [cac_pkg::COLOUR_W-1:0] c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    tail_vertex <= t;
    head_vertex <= h;
    colour      <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // stop sending until every result is back, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access phase, then psel, penable and pwrite are dropped
  task automatic write_register(input logic [cac_pkg::ADDR_W-1:0] addr,
                                input logic [cac_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [cac_pkg::VERT_W-1:0] raw_n, input logic guard);
    write_register({cac_pkg::REG_VERTEX_COUNT, 2'b00}, {28'($urandom), raw_n});
    write_register({cac_pkg::REG_RAINBOW_GUARD, 2'b00}, {31'($urandom), guard});
    settings_used++;
  endtask

  // mostly well-formed arcs, some forward-only arcs from tails above 0, some clears, some noise
  task automatic send_random(input int n, input int fwd_pct, input int clear_pct);
    int         roll;
    int         t;
    int         h;
    logic [1:0] act;
    roll = $urandom_range(99);
    if (roll < clear_pct) begin
      send_request(cac_pkg::ACT_CLEAR, 4'($urandom), 4'($urandom), 2'($urandom));
    end else if (roll < clear_pct + 8) begin
      act = 2'($urandom_range(2));
      if (act == cac_pkg::ACT_CLEAR) act = ACT_UNUSED;
      send_request(act, 4'($urandom), 4'($urandom), 2'($urandom));
    end else if (roll < clear_pct + 8 + fwd_pct) begin
      t = $urandom_range(n - 2, 1);
      h = $urandom_range(n - 1, t + 1);
      act = ($urandom_range(9) == 0) ? cac_pkg::ACT_PROBE : cac_pkg::ACT_INSERT;
      send_request(act, 4'(t), 4'(h), 2'($urandom));
    end else begin
      t = $urandom_range(n - 1);
      h = (t + $urandom_range(n - 1, 1)) % n;
      act = ($urandom_range(99) < 60) ? cac_pkg::ACT_INSERT : cac_pkg::ACT_PROBE;
      send_request(act, 4'(t), 4'(h), 2'($urandom));
    end
  endtask

  task automatic run_phase(input logic [cac_pkg::VERT_W-1:0] raw_n, input logic guard,
                           input int send_idle, input int recv_stall, input int count,
                           input int fwd_pct, input int clear_pct, input bit hold_mid);
    int n;
    wait_drained();
    set_registers(raw_n, guard);
    n = int'(raw_n);
    if (n < int'(cac_pkg::MIN_VERTICES)) n = int'(cac_pkg::MIN_VERTICES);
    if (n > cac_pkg::MAX_VERTICES) n = cac_pkg::MAX_VERTICES;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int k = 0; k < count; k++) begin
      if (hold_mid && k == count / 2) wait_drained();
      send_random(n, fwd_pct, clear_pct);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, bad vertices, unused action, reach rejects, overwrite
    set_registers(4'd12, 1'b0);
    send_request(cac_pkg::ACT_INSERT, 4'd0, 4'd1, 2'd0);
    send_request(cac_pkg::ACT_PROBE, 4'd1, 4'd0, 2'd0);
    send_request(cac_pkg::ACT_INSERT, 4'd3, 4'd3, 2'd1);
    send_request(cac_pkg::ACT_INSERT, 4'd12, 4'd0, 2'd1);
    send_request(cac_pkg::ACT_PROBE, 4'd0, 4'd15, 2'd2);
    send_request(ACT_UNUSED, 4'd2, 4'd5, 2'd3);
    send_request(cac_pkg::ACT_INSERT, 4'd5, 4'd6, 2'd3);
    send_request(cac_pkg::ACT_INSERT, 4'd0, 4'd1, 2'd2);
    send_request(cac_pkg::ACT_INSERT, 4'd0, 4'd1, 2'd0);
    send_request(cac_pkg::ACT_INSERT, 4'd4, 4'd1, 2'd0);
    send_request(cac_pkg::ACT_INSERT, 4'd4, 4'd7, 2'd1);
    send_request(cac_pkg::ACT_INSERT, 4'd7, 4'd2, 2'd2);
    send_request(cac_pkg::ACT_PROBE, 4'd2, 4'd4, 2'd0);

    // directed: rainbow triangle check on, its priority, then clear
    wait_drained();
    set_registers(4'd12, 1'b1);
    send_request(cac_pkg::ACT_PROBE, 4'd2, 4'd4, 2'd0);
    send_request(cac_pkg::ACT_PROBE, 4'd2, 4'd4, 2'd1);
    send_request(cac_pkg::ACT_INSERT, 4'd2, 4'd4, 2'd3);
    send_request(cac_pkg::ACT_INSERT, 4'd2, 4'd2, 2'd0);
    send_request(cac_pkg::ACT_INSERT, 4'd11, 4'd0, 2'd0);
    send_request(cac_pkg::ACT_CLEAR, 4'd0, 4'd0, 2'd0);
    send_request(cac_pkg::ACT_INSERT, 4'd10, 4'd11, 2'd3);

    // random phases over register settings and idling patterns
    run_phase(4'd12, 1'b0, 0, 0, 220, 85, 0, 1'b1);
    run_phase(4'd5, 1'b1, 88, 0, 150, 30, 4, 1'b0);
    run_phase(4'd0, 1'b1, 0, 88, 100, 30, 4, 1'b0);
    run_phase(4'd15, 1'b0, 38, 38, 150, 40, 3, 1'b0);
    run_phase(4'd7, 1'b1, 0, 0, 130, 25, 3, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d requests across %0d register settings, %0d results compared",
             requests_sent, settings_used, results_checked);
    if (fail_count == 0) begin
      $display("coloured_arc_closure_insert_core_tb: done, clean");
    end else begin
      $display("coloured_arc_closure_insert_core_tb: done, errors");
    end
    $finish;
  end

endmodule
